// File: design/otr_pkg.sv
// Shared types and codes for the outstanding command tracker.
// Depends on nothing; every other file of the block imports it.
package otr_pkg;

	typedef enum logic [1:0] {
		KIND_ISSUE   = 2'd0,
		KIND_RESP    = 2'd1,
		KIND_TIMEOUT = 2'd2,
		KIND_FLUSH   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		EV_ISSUED     = 4'd0,
		EV_QUEUE_FULL = 4'd1,
		EV_TABLE_FULL = 4'd2,
		EV_EXPIRED    = 4'd3,
		EV_MATCHED    = 4'd4,
		EV_DROPPED    = 4'd5,
		EV_REMOVED    = 4'd6,
		EV_NOT_FOUND  = 4'd7,
		EV_FLUSHED    = 4'd8,
		EV_FLUSH_DONE = 4'd9
	} event_t;

	// One result as produced by a sub-unit, before the output register.
	typedef struct packed {
		logic        vld;
		event_t      ev;
		logic [63:0] seq;
		logic        entry_async;
		logic        last;
	} res_t;

	// Pending-entry write from the issue unit to the pending store.
	typedef struct packed {
		logic        en;
		logic [63:0] seq;
		logic        entry_async;
	} push_t;

endpackage

// File: design/otr_issue.sv
// Issue unit: command ring tail with wrap bit and the sequence counter.
// Depends on otr_pkg; decides an issue transfer in the cycle it is accepted.
module otr_issue #(
	parameter int CMD_DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic                       want_response,
	input  logic                       is_async,
	input  logic [7:0]                 seq_step,
	input  logic [$clog2(CMD_DEPTH):0] cmd_head,
	input  logic                       pend_full,
	output otr_pkg::res_t              res,
	output logic [$clog2(CMD_DEPTH)-1:0] slot,
	output otr_pkg::push_t             push
);
	import otr_pkg::*;

	localparam int CW = $clog2(CMD_DEPTH);

	logic [CW:0] tail_q;
	logic [63:0] next_seq_q;
	logic        ring_full;
	logic        table_full;
	logic        ok;

	assign ring_full  = cmd_head == {~tail_q[CW], tail_q[CW-1:0]};
	assign table_full = want_response && pend_full;
	assign ok         = !ring_full && !table_full;

	always_comb begin
		res.vld         = go;
		res.seq         = next_seq_q;
		res.entry_async = ok && is_async && want_response;
		res.last        = 1'b1;
		if (ring_full) begin
			res.ev = EV_QUEUE_FULL;
		end else if (table_full) begin
			res.ev = EV_TABLE_FULL;
		end else begin
			res.ev = EV_ISSUED;
		end
	end

	assign slot             = ok ? tail_q[CW-1:0] : '0;
	assign push.en          = go && ok && want_response;
	assign push.seq         = next_seq_q;
	assign push.entry_async = is_async;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q     <= '0;
			next_seq_q <= '0;
		end else if (go && ok) begin
			tail_q     <= tail_q + 1'b1;
			next_seq_q <= next_seq_q + 64'(seq_step);
		end
	end

endmodule

// File: design/otr_pend.sv
// Pending store: sequence/async memory, valid flops, FIFO pointers and the
// walker that serves response, timeout and flush transfers. Depends on otr_pkg.
module otr_pend #(
	parameter int PENDING_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic [1:0]     kind,
	input  logic [63:0]    resp_seq,
	input  otr_pkg::push_t push,
	output logic           full,
	output logic           busy,
	output otr_pkg::res_t  res
);
	import otr_pkg::*;

	localparam int PW = $clog2(PENDING_DEPTH);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_CHK  = 5'b00100,
		ST_FIN  = 5'b01000,
		ST_SKIP = 5'b10000
	} state_t;

	state_t                     state_q;
	kind_t                      kind_q;
	logic [63:0]                rseq_q;
	logic [PW:0]                head_q;
	logic [PW:0]                tail_q;
	logic [PW:0]                ptr_q;
	logic [PW:0]                rem_q;
	logic [PENDING_DEPTH-1:0]   valid_q;
	logic [64:0]                mem [PENDING_DEPTH];
	logic [64:0]                rd_q;
	logic [PW:0]                used;
	logic                       gt;
	logic                       eq;

	assign used = tail_q - head_q;
	assign full = used[PW];
	assign busy = state_q != ST_IDLE;
	assign gt   = rd_q[63:0] > rseq_q;
	assign eq   = rd_q[63:0] == rseq_q;

	// entry = {async, seq}; read data is registered, valid in the cycle after the address
	always_ff @(posedge clk) begin
		if (push.en) begin
			mem[tail_q[PW-1:0]] <= {push.entry_async, push.seq};
		end
		rd_q <= mem[ptr_q[PW-1:0]];
	end

	always_comb begin
		res = '{vld: 1'b0, ev: EV_DROPPED, seq: rd_q[63:0], entry_async: rd_q[64],
			last: 1'b0};
		case (state_q)
			ST_CHK: begin
				case (kind_q)
					KIND_RESP: begin
						res.vld  = !gt;
						res.ev   = eq ? EV_MATCHED : EV_EXPIRED;
						res.last = eq;
					end
					KIND_TIMEOUT: begin
						res.vld  = eq;
						res.ev   = EV_REMOVED;
						res.last = 1'b1;
					end
					default: begin
						res.vld = 1'b1;
						res.ev  = EV_FLUSHED;
					end
				endcase
			end
			ST_FIN: begin
				res.vld         = 1'b1;
				res.last        = 1'b1;
				res.entry_async = 1'b0;
				res.seq         = rseq_q;
				case (kind_q)
					KIND_RESP:    res.ev = EV_DROPPED;
					KIND_TIMEOUT: res.ev = EV_NOT_FOUND;
					default: begin
						res.ev  = EV_FLUSH_DONE;
						res.seq = '0;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= KIND_RESP;
			rseq_q  <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			ptr_q   <= '0;
			rem_q   <= '0;
			valid_q <= '0;
		end else begin
			if (push.en) begin
				valid_q[tail_q[PW-1:0]] <= 1'b1;
				tail_q                  <= tail_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						state_q <= ST_RD;
						kind_q  <= kind_t'(kind);
						rseq_q  <= resp_seq;
						ptr_q   <= head_q;
						rem_q   <= used;
					end
				end
				ST_RD: begin
					if (rem_q == '0) begin
						state_q <= ST_FIN;
					end else if (!valid_q[ptr_q[PW-1:0]]) begin
						// hole: step over it
						ptr_q <= ptr_q + 1'b1;
						rem_q <= rem_q - 1'b1;
						if (kind_q == KIND_RESP) begin
							head_q <= ptr_q + 1'b1;
						end
					end else begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					case (kind_q)
						KIND_RESP: begin
							if (gt) begin
								state_q <= ST_FIN;
							end else begin
								valid_q[ptr_q[PW-1:0]] <= 1'b0;
								ptr_q   <= ptr_q + 1'b1;
								rem_q   <= rem_q - 1'b1;
								head_q  <= ptr_q + 1'b1;
								state_q <= eq ? ST_SKIP : ST_RD;
							end
						end
						KIND_TIMEOUT: begin
							if (gt) begin
								state_q <= ST_FIN;
							end else if (eq) begin
								valid_q[ptr_q[PW-1:0]] <= 1'b0;
								state_q <= ST_SKIP;
							end else begin
								ptr_q   <= ptr_q + 1'b1;
								rem_q   <= rem_q - 1'b1;
								state_q <= ST_RD;
							end
						end
						default: begin
							valid_q[ptr_q[PW-1:0]] <= 1'b0;
							ptr_q   <= ptr_q + 1'b1;
							rem_q   <= rem_q - 1'b1;
							state_q <= ST_RD;
						end
					endcase
				end
				ST_FIN: begin
					if (kind_q == KIND_FLUSH) begin
						head_q  <= tail_q;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (used != '0 && !valid_q[head_q[PW-1:0]]) begin
						head_q <= head_q + 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: design/outstanding_command_tracker.sv
// Outstanding command tracker: top level, output register and transfer accept.
// Depends on otr_pkg, otr_issue and otr_pend.
//
// A transfer is taken when start is high and busy low. Issue transfers settle
// in the cycle they are taken, so one may be accepted every cycle while busy
// is low. Response, timeout and flush transfers walk the pending FIFO through
// its memory: each valid entry visited is addressed, then compared on the
// registered read data; a hole is stepped over. A transfer that ends without a
// match or removal gives a closing result; response and timeout walks then skip
// holes at the head. Busy is held for the whole walk. Each result sits on the
// outputs for exactly one cycle with strobe high, in the cycle after it is
// produced; the receiver cannot stall it, so it must take every result
// it is shown. last marks the final result of a transfer.
module outstanding_command_tracker #(
	parameter int CMD_DEPTH     = 32,
	parameter int PENDING_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   kind,
	input  logic                         want_response,
	input  logic                         is_async,
	input  logic [7:0]                   seq_step,
	input  logic [$clog2(CMD_DEPTH):0]   cmd_head,
	input  logic [63:0]                  resp_seq,
	output logic                         strobe,
	output logic [3:0]                   event_res,
	output logic [63:0]                  seq,
	output logic                         entry_async,
	output logic [$clog2(CMD_DEPTH)-1:0] cmd_slot,
	output logic                         last
);
	import otr_pkg::*;

	localparam int CW = $clog2(CMD_DEPTH);

	logic          accept;
	logic          iss_go;
	logic          pend_go;
	logic          pend_full;
	res_t          iss_res;
	res_t          pend_res;
	push_t         push;
	logic [CW-1:0] iss_slot;
	res_t          out_q;
	logic [CW-1:0] slot_q;

	assign accept  = start && !busy;
	assign iss_go  = accept && kind == KIND_ISSUE;
	assign pend_go = accept && kind != KIND_ISSUE;

	otr_issue #(
		.CMD_DEPTH(CMD_DEPTH)
	) u_issue (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (iss_go),
		.want_response(want_response),
		.is_async     (is_async),
		.seq_step     (seq_step),
		.cmd_head     (cmd_head),
		.pend_full    (pend_full),
		.res          (iss_res),
		.slot         (iss_slot),
		.push         (push)
	);

	otr_pend #(
		.PENDING_DEPTH(PENDING_DEPTH)
	) u_pend (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (pend_go),
		.kind    (kind),
		.resp_seq(resp_seq),
		.push    (push),
		.full    (pend_full),
		.busy    (busy),
		.res     (pend_res)
	);

	// Output register. The two sources never produce in the same cycle:
	// an issue transfer is only taken while the walker is idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q  <= '0;
			slot_q <= '0;
		end else begin
			out_q.vld <= iss_res.vld || pend_res.vld;
			if (iss_res.vld) begin
				out_q.ev          <= iss_res.ev;
				out_q.seq         <= iss_res.seq;
				out_q.entry_async <= iss_res.entry_async;
				out_q.last        <= iss_res.last;
				slot_q            <= iss_slot;
			end else begin
				out_q.ev          <= pend_res.ev;
				out_q.seq         <= pend_res.seq;
				out_q.entry_async <= pend_res.entry_async;
				out_q.last        <= pend_res.last;
				slot_q            <= '0;
			end
		end
	end

	assign strobe      = out_q.vld;
	assign event_res   = out_q.ev;
	assign seq         = out_q.seq;
	assign entry_async = out_q.entry_async;
	assign cmd_slot    = slot_q;
	assign last        = out_q.last;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for outstanding_command_tracker: directed corner cases, then random
// command traffic in idle phases, each result checked against an in-bench model.
// Depends on otr_pkg and the design sources.
module tb_top;
	import otr_pkg::*;

	localparam int CMD_DEPTH    = 32;
	localparam int PEND_DEPTH   = 16;
	localparam int SLOT_W       = $clog2(CMD_DEPTH);
	localparam int CPTR_W       = SLOT_W + 1;
	localparam int PPTR_W       = $clog2(PEND_DEPTH) + 1;
	localparam int PIDX_W       = PPTR_W - 1;
	localparam int RANDOM_ITEMS = 102;
	// longest walk of the pending FIFO plus output register and some slack
	localparam int WALK_CYCLES  = 3 * PEND_DEPTH + 8;
	// ~130 transfers in all; the watchdog limit leaves a wide margin
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_PRINTS   = 40;

	// one expected result of the tracker
	typedef struct {
		event_t              ev;
		logic [63:0]         seq;
		logic                entry_async;
		logic [SLOT_W-1:0]   cmd_slot;
		logic                last;
	} tracker_result_t;

	// Mirrors the tracker state, turns every accepted transfer into the results it
	// should cause, and checks the results the tracker actually shows.
	class tracker_scoreboard;
		logic [63:0]       next_seq;
		logic [CPTR_W-1:0] cmd_tail;
		logic [63:0]       open_seq [PEND_DEPTH];
		logic              open_async [PEND_DEPTH];
		logic              open_valid [PEND_DEPTH];
		logic [PPTR_W-1:0] open_head;
		logic [PPTR_W-1:0] open_tail;
		tracker_result_t   awaited [$];
		int unsigned       errors;

		function new();
			next_seq  = '0;
			cmd_tail  = '0;
			open_head = '0;
			open_tail = '0;
			errors    = 0;
			foreach (open_valid[i]) begin
				open_seq[i]   = '0;
				open_async[i] = 1'b0;
				open_valid[i] = 1'b0;
			end
		endfunction

		function logic [PPTR_W-1:0] used_slots();
			return open_tail - open_head;
		endfunction

		function void await_result(event_t ev, logic [63:0] s, logic a, logic [SLOT_W-1:0] slot);
			tracker_result_t r;
			r.ev          = ev;
			r.seq         = s;
			r.entry_async = a;
			r.cmd_slot    = slot;
			r.last        = 1'b0;
			awaited.push_back(r);
		endfunction

		// the head never rests on a removed entry
		function void skip_holes();
			while (used_slots() != 0 && !open_valid[open_head[PIDX_W-1:0]])
				open_head = open_head + 1'b1;
		endfunction

		function void note_command(kind_t k, logic want, logic is_as, logic [7:0] step,
				logic [CPTR_W-1:0] head, logic [63:0] rseq);
			logic [PIDX_W-1:0] p;
			logic [PPTR_W-1:0] cnt;
			logic              hit;
			int                i;
			hit = 1'b0;
			case (k)
			KIND_ISSUE: begin
				if (head == (cmd_tail ^ CPTR_W'(CMD_DEPTH))) begin
					await_result(EV_QUEUE_FULL, next_seq, 1'b0, '0);
				end else if (want && used_slots() >= PPTR_W'(PEND_DEPTH)) begin
					await_result(EV_TABLE_FULL, next_seq, 1'b0, '0);
				end else begin
					if (want) begin
						p             = open_tail[PIDX_W-1:0];
						open_seq[p]   = next_seq;
						open_async[p] = is_as;
						open_valid[p] = 1'b1;
						open_tail     = open_tail + 1'b1;
					end
					await_result(EV_ISSUED, next_seq, is_as & want, cmd_tail[SLOT_W-1:0]);
					cmd_tail = cmd_tail + 1'b1;
					next_seq = next_seq + 64'(step);
				end
			end
			KIND_RESP: begin
				// older entries expire until the match or a younger one
				while (used_slots() != 0) begin
					p = open_head[PIDX_W-1:0];
					if (!open_valid[p]) begin
						open_head = open_head + 1'b1;
						continue;
					end
					if (open_seq[p] > rseq)
						break;
					open_valid[p] = 1'b0;
					open_head     = open_head + 1'b1;
					if (open_seq[p] == rseq) begin
						await_result(EV_MATCHED, open_seq[p], open_async[p], '0);
						hit = 1'b1;
						break;
					end
					await_result(EV_EXPIRED, open_seq[p], open_async[p], '0);
				end
				if (!hit)
					await_result(EV_DROPPED, rseq, 1'b0, '0);
				skip_holes();
			end
			KIND_TIMEOUT: begin
				cnt = used_slots();
				for (i = 0; i < int'(cnt); i++) begin
					p = open_head[PIDX_W-1:0] + PIDX_W'(i);
					if (!open_valid[p])
						continue;
					if (open_seq[p] > rseq)
						break;
					if (open_seq[p] == rseq) begin
						open_valid[p] = 1'b0;
						await_result(EV_REMOVED, open_seq[p], open_async[p], '0);
						hit = 1'b1;
						break;
					end
				end
				if (!hit)
					await_result(EV_NOT_FOUND, rseq, 1'b0, '0);
				skip_holes();
			end
			KIND_FLUSH: begin
				cnt = used_slots();
				for (i = 0; i < int'(cnt); i++) begin
					p = open_head[PIDX_W-1:0] + PIDX_W'(i);
					if (open_valid[p]) begin
						await_result(EV_FLUSHED, open_seq[p], open_async[p], '0);
						open_valid[p] = 1'b0;
					end
				end
				open_head = open_tail;
				await_result(EV_FLUSH_DONE, '0, 1'b0, '0);
			end
			default: ;
			endcase
			awaited[awaited.size() - 1].last = 1'b1;
		endfunction

		// sequence of a live entry, the oldest or any, for well-formed responses
		function bit pick_open(bit oldest, output logic [63:0] s);
			logic [63:0]       live [$];
			logic [PIDX_W-1:0] p;
			int                i;
			s = '0;
			for (i = 0; i < int'(used_slots()); i++) begin
				p = open_head[PIDX_W-1:0] + PIDX_W'(i);
				if (open_valid[p])
					live.push_back(open_seq[p]);
			end
			if (live.size() == 0)
				return 1'b0;
			s = oldest ? live[0] : live[$urandom_range(live.size() - 1)];
			return 1'b1;
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		task check_result(logic [3:0] ev, logic [63:0] s, logic a, logic [SLOT_W-1:0] slot,
				logic l);
			tracker_result_t e;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("unexpected result ev=%0d seq=%h", ev, s));
				return;
			end
			e = awaited.pop_front();
			if (ev !== e.ev || s !== e.seq || a !== e.entry_async || slot !== e.cmd_slot
					|| l !== e.last)
				report_mismatch($sformatf(
					"got ev=%0d seq=%h as=%b slot=%0d last=%b; want %s seq=%h as=%b slot=%0d last=%b",
					ev, s, a, slot, l, e.ev.name(), e.seq, e.entry_async, e.cmd_slot, e.last));
		endtask

		task finish_check();
			if (awaited.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", awaited.size()));
		endtask
	endclass

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              start         = 1'b0;
	logic [1:0]        kind          = '0;
	logic              want_response = 1'b0;
	logic              is_async      = 1'b0;
	logic [7:0]        seq_step      = '0;
	logic [CPTR_W-1:0] cmd_head      = '0;
	logic [63:0]       resp_seq      = '0;
	logic              busy;
	logic              strobe;
	logic [3:0]        event_res;
	logic [63:0]       seq;
	logic              entry_async;
	logic [SLOT_W-1:0] cmd_slot;
	logic              last;

	tracker_scoreboard sb = new();
	int unsigned       cycle_count = 0;
	// sender idle percentages: a run with no gaps, a heavy one and a moderate one
	int unsigned       idle_pct [3] = '{0, 46, 27};

	outstanding_command_tracker #(
		.CMD_DEPTH     (CMD_DEPTH),
		.PENDING_DEPTH (PEND_DEPTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.want_response (want_response),
		.is_async      (is_async),
		.seq_step      (seq_step),
		.cmd_head      (cmd_head),
		.resp_seq      (resp_seq),
		.strobe        (strobe),
		.event_res     (event_res),
		.seq           (seq),
		.entry_async   (entry_async),
		.cmd_slot      (cmd_slot),
		.last          (last)
	);

	always #5 clk = ~clk;

	// watchdog: a hung handshake or a lost result ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Results cannot be held off, so every strobe is a transfer taken at this edge.
	// The values read here are the ones before this edge's updates.
	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1)
			sb.check_result(event_res, seq, entry_async, cmd_slot, last);
	end

	// Present one command and hold it until the transfer is taken. Called at a
	// rising edge; returns at the edge that took it, so a following send keeps
	// start high with a single assignment.
	task automatic send(kind_t k, bit w, bit a, logic [7:0] st, logic [CPTR_W-1:0] hd,
			logic [63:0] rs);
		kind          <= k;
		want_response <= w;
		is_async      <= a;
		seq_step      <= st;
		cmd_head      <= hd;
		resp_seq      <= rs;
		start         <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_command(k, w, a, st, hd, rs);
	endtask

	// random gap of random length, taken at the given percentage, so that idling lands on every step of a walk
	task automatic pause_sender(int unsigned pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// hold off until every expected result has been seen; polled on the falling
	// edge to stay clear of the checker
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(negedge clk);
		while (sb.awaited.size() != 0);
		@(posedge clk);
	endtask

	// Mostly well-formed traffic: issues that build up entries, responses and
	// timeouts that name a live sequence, rare flushes; the rest is noise sequences.
	task automatic random_item();
		int unsigned pick;
		logic [63:0] s;
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		pick  = $urandom_range(99);
		if (pick < 50) begin
			send(KIND_ISSUE, $urandom_range(99) < 80, 1'($urandom_range(1)),
				($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'd1,
				($urandom_range(9) == 0) ? (sb.cmd_tail ^ CPTR_W'(CMD_DEPTH))
					: CPTR_W'($urandom_range(63)),
				noise);
		end else if (pick < 94) begin
			if ($urandom_range(3) == 0 || !sb.pick_open(1'($urandom_range(1)), s))
				s = $urandom_range(1) ? noise : 64'($urandom_range(300));
			send((pick < 78) ? KIND_RESP : KIND_TIMEOUT, 1'($urandom_range(1)),
				1'($urandom_range(1)), 8'($urandom_range(255)),
				CPTR_W'($urandom_range(63)), s);
		end else begin
			send(KIND_FLUSH, 1'($urandom_range(1)), 1'($urandom_range(1)),
				8'($urandom_range(255)), CPTR_W'($urandom_range(63)), noise);
		end
	endtask

	initial begin
		int ph;
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty FIFO: flush gives only its closing result, response drops, timeout misses
		send(KIND_FLUSH, 1'b0, 1'b0, 8'd0, '0, '0);
		send(KIND_RESP, 1'b1, 1'b1, 8'd255, '1, 64'd0);
		send(KIND_TIMEOUT, 1'b0, 1'b0, 8'd0, '0, '1);
		// no response wanted, zero step: seq stays 0
		send(KIND_ISSUE, 1'b0, 1'b0, 8'd0, '0, '1);
		// ring full: head equals tail with the wrap bit flipped
		send(KIND_ISSUE, 1'b1, 1'b1, 8'd1, sb.cmd_tail ^ CPTR_W'(CMD_DEPTH), '0);
		// fill the pending FIFO: seqs 0, 255, 256 .. 269
		for (n = 0; n < PEND_DEPTH; n++)
			send(KIND_ISSUE, 1'b1, n[0], (n == 0) ? 8'd255 : 8'd1, '1, '0);
		// FIFO full refuses a response-wanting issue but not a fire-and-forget one
		send(KIND_ISSUE, 1'b1, 1'b0, 8'd1, '0, '0);
		send(KIND_ISSUE, 1'b0, 1'b1, 8'd1, '0, '0);
		// timeout leaves a hole in the middle, then a miss below a live entry
		send(KIND_TIMEOUT, 1'b0, 1'b0, 8'd0, '0, 64'd256);
		send(KIND_TIMEOUT, 1'b0, 1'b0, 8'd0, '0, 64'd100);
		// response past the hole: three expire, then the match
		send(KIND_RESP, 1'b0, 1'b0, 8'd0, '0, 64'd258);
		send(KIND_FLUSH, 1'b0, 1'b0, 8'd0, '0, '0);
		wait_drained();

		// random traffic, one idle setting per phase, drained between phases
		for (ph = 0; ph < 3; ph++) begin
			for (n = 0; n < (RANDOM_ITEMS + 2) / 3; n++) begin
				random_item();
				pause_sender(idle_pct[ph]);
			end
			wait_drained();
		end

		repeat (WALK_CYCLES) @(posedge clk);
		sb.finish_check();
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
design/otr_pkg.sv
design/otr_issue.sv
design/otr_pend.sv
design/outstanding_command_tracker.sv
test/tb_top.sv
